FILE: rtl/rrmr_pkg.sv
package rrmr_pkg;

   localparam int MAX_MEMBERS = 16;
   localparam int IDX_W       = $clog2(MAX_MEMBERS);
   localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
   localparam int ID_W        = 16;
   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 5;

   // commands
   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SKIP   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd4;

   // response status
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_PROGRESS  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_WINNER    = 3'd5;

   // cell operations
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_ROTATE = 2'd2;
   localparam logic [1:0] OP_SWEEP  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  member_id;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ID_W-1:0]        current_id;
      logic [ID_W-1:0]        skipped_id;
      logic [COUNT_OUT_W-1:0] member_count;
   } rsp_payload_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] sel;
      logic             found;
      logic [ID_W-1:0]  id;
   } ring_ctl_type;

endpackage

FILE: rtl/round_robin_member_ring.sv
// round-robin member ring
//
// keeps up to MAX_MEMBERS member ids in turn order; cell 0 always holds the
// current member and cell k the member k turns later
// req channel: one command transfer (add, remove, next, skip, check) with an id
// rsp channel: exactly one response transfer per command (status, current id,
// skipped id, member count after the command)
// commands are handled one at a time: accept, work, reply
//   add, next, check: work step, then reply step
//   skip: two single-place rotations of the cell row in the work step, then reply
//   remove: the work step repeats while the match sweep walks the live part
//   one cell per cycle and closes the gap behind it; an empty ring skips the sweep
// the next command is accepted, at the earliest, in the cycle after the response is loaded
// the response sits in an output register; a new command is accepted while it
// waits, and the command only stalls in its reply step if the receiver still
// holds off the previous transfer
// reset empties the ring and drops any pending response; cell contents stay
// undefined and are never read outside the live part
module round_robin_member_ring
   import rrmr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WORK  = 2'd1;
   localparam logic [1:0] ST_REPLY = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_ff, rsp_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic                found_ff, found_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     skipped_ff, skipped_in;

   ring_ctl_type        ctl;
   logic [ID_W-1:0]     cell_ids [MAX_MEMBERS];
   logic [MAX_MEMBERS-1:0] hit_vec;
   logic                hit_any;
   logic                sweep_found;
   logic [IDX_W-1:0]    last_idx;
   logic                is_empty;
   logic                is_full;
   logic                out_free;

   // row of cells, each linked to its successor, the last back to cell 0
   for (genvar k = 0; k < MAX_MEMBERS; k++) begin : g_cell
      localparam int NEXT = (k + 1) % MAX_MEMBERS;
      rrmr_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_index (IDX_W'(k)),
         .next_id    (cell_ids[NEXT]),
         .head_id    (cell_ids[0]),
         .stored_id  (cell_ids[k]),
         .hit        (hit_vec[k])
      );
   end

   assign hit_any     = |hit_vec;
   assign sweep_found = found_ff | hit_any;
   assign last_idx    = IDX_W'(count_ff - CNT_W'(1));
   assign is_empty    = (count_ff == '0);
   assign is_full     = (count_ff == CNT_W'(MAX_MEMBERS));
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      skipped_in   = skipped_ff;
      ctl.op       = OP_HOLD;
      ctl.sel      = '0;
      ctl.found    = found_ff;
      ctl.id       = id_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_payload.cmd;
               id_in      = req_payload.member_id;
               step_in    = '0;
               found_in   = 1'b0;
               status_in  = STATUS_OK;
               skipped_in = '0;
               state_in   = ST_WORK;
            end
         end
         ST_WORK: begin
            state_in = ST_REPLY;
            unique case (cmd_ff)
               CMD_ADD: begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     // new member goes to the tail, just before the current one
                     ctl.op   = OP_LOAD;
                     ctl.sel  = IDX_W'(count_ff);
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_REMOVE: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ctl.op   = OP_SWEEP;
                     ctl.sel  = step_ff;
                     found_in = sweep_found;
                     if (step_ff == last_idx) begin
                        if (sweep_found) count_in = count_ff - CNT_W'(1);
                        else status_in = STATUS_NOT_FOUND;
                     end else begin
                        step_in  = step_ff + IDX_W'(1);
                        state_in = ST_WORK;
                     end
                  end
               end
               CMD_NEXT: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ctl.op  = OP_ROTATE;
                     ctl.sel = last_idx;
                  end
               end
               CMD_SKIP: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ctl.op  = OP_ROTATE;
                     ctl.sel = last_idx;
                     if (step_ff == '0) begin
                        // a lone member passes over itself
                        skipped_in = (count_ff == CNT_W'(1)) ? cell_ids[0] : cell_ids[1];
                        step_in    = IDX_W'(1);
                        state_in   = ST_WORK;
                     end
                  end
               end
               CMD_CHECK: begin
                  if (is_empty) status_in = STATUS_EMPTY;
                  else if (count_ff == CNT_W'(1)) status_in = STATUS_WINNER;
                  else status_in = STATUS_PROGRESS;
               end
               default: ;
            endcase
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.current_id   = is_empty ? '0 : cell_ids[0];
               rsp_in.skipped_id   = skipped_ff;
               rsp_in.member_count = COUNT_OUT_W'(count_ff);
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command and response payload
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      cmd_ff     <= cmd_in;
      id_ff      <= id_in;
      step_ff    <= step_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
      skipped_ff <= skipped_in;
   end

   // the ring never holds more than its capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_MEMBERS))
      else $error("member count above capacity");

   // membership only changes while a command is being worked on
   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_WORK) |=> $stable(count_ff))
      else $error("member count changed outside the work step");

   // the sweep selects one cell, so at most one cell reports a match
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell matched");

   // a reply step with a free output register always produces a response
   a_reply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("reply step did not load the response");

endmodule

FILE: rtl/rrmr_cell.sv
module rrmr_cell
   import rrmr_pkg::*;
(
   input  logic             clock,
   input  ring_ctl_type     ctl,
   input  logic [IDX_W-1:0] cell_index,
   input  logic [ID_W-1:0]  next_id,
   input  logic [ID_W-1:0]  head_id,
   output logic [ID_W-1:0]  stored_id,
   output logic             hit
);

   logic [ID_W-1:0] id_ff;
   logic [ID_W-1:0] id_in;
   logic            at_sel;

   assign at_sel    = (cell_index == ctl.sel);
   assign hit       = at_sel && (id_ff == ctl.id);
   assign stored_id = id_ff;

   always_comb begin
      id_in = id_ff;
      unique case (ctl.op)
         OP_LOAD: begin
            if (at_sel) id_in = ctl.id;
         end
         OP_ROTATE: begin
            // live part moves one place toward the head, head wraps to the last live cell
            if (cell_index < ctl.sel) id_in = next_id;
            else if (at_sel) id_in = head_id;
         end
         OP_SWEEP: begin
            // once the match is found every later cell closes the gap
            if (at_sel && (ctl.found || id_ff == ctl.id)) id_in = next_id;
         end
         default: id_in = id_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

endmodule

FILE: tb/sv/round_robin_member_ring_tb.sv
`timescale 1ns / 1ps

module round_robin_member_ring_tb;
   import rrmr_pkg::*;

   // command codes the block must ignore
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   localparam int RANDOM_ITEMS = 1230;
   localparam int CALM_ITEMS   = 150;   // tail of the run with no idling at all
   localparam int HOLD_CYCLES  = 250;   // long receiver hold-off
   localparam int HOLD_AFTER   = 400;   // commands accepted before that hold-off

   // ------------------------------------------------------------------------
   // scoreboard: keeps its own copy of the ring and the replies still owed
   // ------------------------------------------------------------------------
   class ring_scoreboard;
      logic [ID_W-1:0] turn_ids [MAX_MEMBERS];
      int head;
      int live;
      rsp_payload_type owed_replies[$];
      int errors;
      int accepted;

      function int slot(int offset);
         return (head + offset) % MAX_MEMBERS;
      endfunction

      // current member moves to the tail, its successor takes the turn
      function void rotate_once();
         turn_ids[slot(live % MAX_MEMBERS)] = turn_ids[slot(0)];
         head = slot(1);
      endfunction

      function void note_request(req_payload_type req);
         rsp_payload_type rsp;
         bit hit;
         rsp = '0;
         rsp.status = STATUS_OK;
         accepted++;
         case (req.cmd)
            CMD_ADD: begin
               if (live >= MAX_MEMBERS) begin
                  rsp.status = STATUS_FULL;
               end else begin
                  turn_ids[slot(live)] = req.member_id;
                  live++;
               end
            end
            CMD_REMOVE: begin
               if (live == 0) begin
                  rsp.status = STATUS_EMPTY;
               end else begin
                  rsp.status = STATUS_NOT_FOUND;
                  hit = 1'b0;
                  // first match in turn order, later members close the gap
                  for (int k = 0; k < live && !hit; k++) begin
                     if (turn_ids[slot(k)] == req.member_id) begin
                        for (int j = k; j + 1 < live; j++)
                           turn_ids[slot(j)] = turn_ids[slot(j + 1)];
                        live--;
                        if (live == 0)
                           head = 0;
                        rsp.status = STATUS_OK;
                        hit = 1'b1;
                     end
                  end
               end
            end
            CMD_NEXT: begin
               if (live == 0)
                  rsp.status = STATUS_EMPTY;
               else
                  rotate_once();
            end
            CMD_SKIP: begin
               if (live == 0) begin
                  rsp.status = STATUS_EMPTY;
               end else begin
                  rsp.skipped_id = turn_ids[slot(1 % live)];
                  rotate_once();
                  rotate_once();
               end
            end
            CMD_CHECK: begin
               if (live == 0)
                  rsp.status = STATUS_EMPTY;
               else if (live == 1)
                  rsp.status = STATUS_WINNER;
               else
                  rsp.status = STATUS_PROGRESS;
            end
            default: begin
            end
         endcase
         rsp.current_id   = (live != 0) ? turn_ids[slot(0)] : '0;
         rsp.member_count = COUNT_OUT_W'(live);
         owed_replies.push_back(rsp);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40)
            $display("mismatch: %s", msg);
      endtask

      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (owed_replies.size() == 0) begin
            report($sformatf("response %h with no command waiting", got));
            return;
         end
         want = owed_replies.pop_front();
         if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.current_id !== want.current_id)
            report($sformatf("current_id got %h want %h", got.current_id, want.current_id));
         if (got.skipped_id !== want.skipped_id)
            report($sformatf("skipped_id got %h want %h", got.skipped_id, want.skipped_id));
         if (got.member_count !== want.member_count)
            report($sformatf("member_count got %0d want %0d",
                             got.member_count, want.member_count));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, block
   // ------------------------------------------------------------------------
   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   ring_scoreboard sb = new();

   bit sender_gaps = 1'b1;    // per-phase switch for sender idling
   bit calm = 1'b0;           // end of run: no idling on either side
   bit long_hold_done = 1'b0;
   logic [ID_W-1:0] id_pool [8];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   round_robin_member_ring dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // ------------------------------------------------------------------------
   // monitor: every transfer is sampled at the edge that completes it
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_payload);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_payload);
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random ready bursts, one long hold-off so the block backs up
   // ------------------------------------------------------------------------
   initial begin
      @(negedge reset);
      forever begin
         if (!long_hold_done && sb.accepted >= HOLD_AFTER) begin
            // sender keeps offering while the reply register stays full
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------------

   // offer one command and hold it until the transfer; valid stays high
   // across back-to-back commands
   task send_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
      req_payload_type item;
      item.cmd       = cmd;
      item.member_id = id;
      if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // mostly ids from a small pool so removes hit and duplicates pile up
   function logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 9) < 7)
         return id_pool[$urandom_range(0, 7)];
      return ID_W'($urandom_range(0, 16'hFFFF));
   endfunction

   // mode 0 fills the ring, mode 1 drains it, mode 2 mixes
   function automatic logic [CMD_W-1:0] pick_cmd(int mode);
      int add_share [3] = '{55, 15, 30};
      int rem_share [3] = '{10, 50, 25};
      int r;
      r = $urandom_range(0, 99);
      if (r < add_share[mode])
         return CMD_ADD;
      r -= add_share[mode];
      if (r < rem_share[mode])
         return CMD_REMOVE;
      r = $urandom_range(0, 19);
      if (r == 0)
         return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      if (r < 7)
         return CMD_NEXT;
      if (r < 13)
         return CMD_SKIP;
      return CMD_CHECK;
   endfunction

   initial begin
      int mode;
      int waited;
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      id_pool[2] = 16'h5A5A;
      id_pool[3] = 16'hA5A5;
      for (int i = 4; i < 8; i++)
         id_pool[i] = ID_W'($urandom_range(0, 16'hFFFF));
      mode = 2;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty ring: everything but add reports empty
      send_command(CMD_CHECK, 16'h0000);
      send_command(CMD_NEXT, 16'hFFFF);
      send_command(CMD_SKIP, 16'h0000);
      send_command(CMD_REMOVE, 16'h0000);
      // ignored commands leave the ring alone
      send_command(CMD_UNUSED_LO, 16'hFFFF);
      send_command(CMD_UNUSED_LO + 3'd1, 16'h0000);
      send_command(CMD_UNUSED_HI, 16'hFFFF);
      // lone member: skip passes over itself, check names the winner,
      // removing it empties the ring
      send_command(CMD_ADD, 16'hFFFF);
      send_command(CMD_SKIP, 16'h0000);
      send_command(CMD_CHECK, 16'h0000);
      send_command(CMD_REMOVE, 16'hFFFF);
      // several members with a duplicate id
      send_command(CMD_ADD, 16'h0000);
      send_command(CMD_ADD, 16'hFFFF);
      send_command(CMD_ADD, 16'hFFFF);
      send_command(CMD_ADD, 16'h8001);
      send_command(CMD_CHECK, 16'h0000);
      send_command(CMD_UNUSED_HI, 16'h8001);
      send_command(CMD_NEXT, 16'h0000);
      send_command(CMD_SKIP, 16'h0000);
      send_command(CMD_REMOVE, 16'h1234);   // not in the ring
      send_command(CMD_REMOVE, 16'hFFFF);   // first match from current
      send_command(CMD_REMOVE, 16'h8001);   // current member, successor takes over

      // random phases; the fill phases run the ring into full
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            mode        = $urandom_range(0, 2);
            sender_gaps = ($urandom_range(0, 3) != 0);
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;
         send_command(pick_cmd(mode), pick_id());
      end
      req_valid <= 1'b0;

      // drain, then give a late stray response time to show up
      waited = 0;
      while (sb.owed_replies.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (sb.owed_replies.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.owed_replies.size()));

      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #6000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
